### hdl/cau_pkg.sv
// Shared widths, operation codes and pipeline payload types for the complex arithmetic unit.
package cau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int KIND_W    = 3;

   // Divider numerator magnitude: (|a| + |b|) shifted up by the fraction bits.
   localparam int NUM_W = WORD_BITS + FRAC_BITS + 2;
   // Divider denominator magnitude: Smith denominator is at most twice a word.
   localparam int DEN_W = WORD_BITS + 2;
   // Exact pre-clip result width: a full divider quotient with sign.
   localparam int RES_W = NUM_W + 1;
   // Smith ratio: magnitude at most one in fixed point, with sign.
   localparam int S_W   = FRAC_BITS + 2;
   // Denominator and numerator sums ahead of the second divide.
   localparam int SUM_W = WORD_BITS + 3;

   localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEG = 3'd4;

   // Item context that travels the whole pipeline.
   typedef struct packed {
      logic [KIND_W-1:0]           kind;
      logic signed [WORD_BITS-1:0] lr;
      logic signed [WORD_BITS-1:0] li;
      logic signed [WORD_BITS-1:0] c;
      logic signed [WORD_BITS-1:0] d;
      logic signed [RES_W-1:0]     res_re;
      logic signed [RES_W-1:0]     res_im;
      logic                        dz;
      logic                        big_c;
   } ctx_type;

   // One stage of the restoring divider, two numerators over one divisor.
   typedef struct packed {
      logic [DEN_W-1:0] rem_a;
      logic [DEN_W-1:0] rem_b;
      logic [NUM_W-1:0] nq_a;
      logic [NUM_W-1:0] nq_b;
      logic [DEN_W-1:0] den;
      logic             neg_a;
      logic             neg_b;
      ctx_type          ctx;
   } div_stage_type;

endpackage

### hdl/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, two numerators share a divisor.
module cau_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [cau_pkg::NUM_W-1:0]    in_num_a,
   input  logic [cau_pkg::NUM_W-1:0]    in_num_b,
   input  logic [cau_pkg::DEN_W-1:0]    in_den,
   input  logic                         in_neg_a,
   input  logic                         in_neg_b,
   input  cau_pkg::ctx_type             in_ctx,
   output logic                         out_valid,
   output logic [cau_pkg::NUM_W-1:0]    out_quo_a,
   output logic [cau_pkg::NUM_W-1:0]    out_quo_b,
   output logic                         out_neg_a,
   output logic                         out_neg_b,
   output cau_pkg::ctx_type             out_ctx
);

   localparam int STEPS = cau_pkg::NUM_W;

   cau_pkg::div_stage_type st_ff [STEPS+1];
   cau_pkg::div_stage_type st_in [STEPS+1];
   logic [STEPS:0]         vld_ff;

   // Load the incoming word with a cleared remainder
   always_comb begin
      st_in[0].rem_a = '0;
      st_in[0].rem_b = '0;
      st_in[0].nq_a  = in_num_a;
      st_in[0].nq_b  = in_num_b;
      st_in[0].den   = in_den;
      st_in[0].neg_a = in_neg_a;
      st_in[0].neg_b = in_neg_b;
      st_in[0].ctx   = in_ctx;
   end

   // Shift in the next numerator bit, subtract when it fits, shift in the quotient bit
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      always_comb begin
         logic [cau_pkg::DEN_W:0] trial_a;
         logic [cau_pkg::DEN_W:0] trial_b;
         logic [cau_pkg::DEN_W:0] dv;
         logic                    bit_a;
         logic                    bit_b;
         st_in[k] = st_ff[k-1];
         dv       = {1'b0, st_ff[k-1].den};
         trial_a  = {st_ff[k-1].rem_a, st_ff[k-1].nq_a[STEPS-1]};
         trial_b  = {st_ff[k-1].rem_b, st_ff[k-1].nq_b[STEPS-1]};
         bit_a    = (trial_a >= dv);
         bit_b    = (trial_b >= dv);
         if (bit_a) begin
            trial_a = trial_a - dv;
         end
         if (bit_b) begin
            trial_b = trial_b - dv;
         end
         st_in[k].rem_a = trial_a[cau_pkg::DEN_W-1:0];
         st_in[k].rem_b = trial_b[cau_pkg::DEN_W-1:0];
         st_in[k].nq_a  = {st_ff[k-1].nq_a[STEPS-2:0], bit_a};
         st_in[k].nq_b  = {st_ff[k-1].nq_b[STEPS-2:0], bit_b};
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STEPS-1:0], in_valid};
      end
   end

   // Advance the stage payloads, hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_quo_a = st_ff[STEPS].nq_a;
   assign out_quo_b = st_ff[STEPS].nq_b;
   assign out_neg_a = st_ff[STEPS].neg_a;
   assign out_neg_b = st_ff[STEPS].neg_b;
   assign out_ctx   = st_ff[STEPS].ctx;

endmodule

### hdl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply, divide (Smith) and negate in saturating fixed point.
// Q16.16 words pass s1, s2, ratio divider, m1, m2, result divider, f1 and the result register.
// Throughput: one word per cycle unless stalled; dividers make one quotient bit per stage.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
module complex_arithmetic_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cau_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_left_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_left_im,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_right_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_right_im,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cau_pkg::WORD_BITS-1:0] rsp_result_re,
   output logic signed [cau_pkg::WORD_BITS-1:0] rsp_result_im,
   output logic                                rsp_divide_by_zero,
   output logic                                rsp_saturated
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int F  = cau_pkg::FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int MW = cau_pkg::S_W + W;
   localparam int TW = cau_pkg::RES_W - W + 1;

   logic adv;

   // Stage 1: input register
   logic             s1_vld_ff;
   cau_pkg::ctx_type s1_ff, s1_in;

   // Stage 2: products, easy results, ratio divide setup
   logic                           s2_vld_ff;
   cau_pkg::ctx_type               s2_ff, s2_in;
   logic signed [PW-1:0]           s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff;
   logic signed [PW-1:0]           s2_p0_in, s2_p1_in, s2_p2_in, s2_p3_in;
   logic [cau_pkg::NUM_W-1:0]      s2_num_ff, s2_num_in;
   logic [cau_pkg::DEN_W-1:0]      s2_den_ff, s2_den_in;
   logic                           s2_neg_ff, s2_neg_in;
   logic signed [W:0]              ext_c, ext_d;
   logic [W:0]                     mag_c, mag_d;
   cau_pkg::ctx_type               d1_ctx_in;
   logic signed [PW:0]             diff_re, diff_im;

   // Ratio divider
   logic                           d1_vld;
   logic [cau_pkg::NUM_W-1:0]      d1_quo;
   logic                           d1_neg;
   cau_pkg::ctx_type               d1_ctx;

   // Smith products and sums
   logic                           m1_vld_ff;
   cau_pkg::ctx_type               m1_ff;
   logic signed [cau_pkg::S_W-1:0] m1_s_ff, m1_s_in;
   logic                           m2_vld_ff;
   cau_pkg::ctx_type               m2_ff;
   logic signed [MW-1:0]           m2_psm_ff, m2_pl_ff, m2_pi_ff;
   logic signed [MW-1:0]           m2_psm_in, m2_pl_in, m2_pi_in;
   logic signed [W-1:0]            m1_small;
   logic signed [cau_pkg::SUM_W-1:0] sum_sd, sum_pl, sum_pi, sum_den, sum_re, sum_im;
   logic [cau_pkg::SUM_W-1:0]      mag_den, mag_re, mag_im;
   logic [cau_pkg::NUM_W-1:0]      d2_num_a_in, d2_num_b_in;
   logic [cau_pkg::DEN_W-1:0]      d2_den_in;
   logic                           d2_neg_a_in, d2_neg_b_in;

   // Result divider
   logic                           d2_vld;
   logic [cau_pkg::NUM_W-1:0]      d2_quo_a, d2_quo_b;
   logic                           d2_neg_a, d2_neg_b;
   cau_pkg::ctx_type               d2_ctx;

   // Final select and clip
   logic                           f1_vld_ff;
   cau_pkg::ctx_type               f1_ff, f1_in;
   logic [TW-1:0]                  top_re, top_im;
   logic                           ovf_re, ovf_im;
   logic                           rsp_valid_ff;
   logic signed [W-1:0]            rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic                           rsp_dz_ff, rsp_sat_ff, rsp_sat_in;

   // Hold every stage while a result word waits
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Capture the request word
   always_comb begin
      s1_in        = '0;
      s1_in.kind   = req_kind;
      s1_in.lr     = req_left_re;
      s1_in.li     = req_left_im;
      s1_in.c      = req_right_re;
      s1_in.d      = req_right_im;
   end

   // Form products, sums, and the ratio divide operands
   always_comb begin
      ext_c = {s1_ff.c[W-1], s1_ff.c};
      ext_d = {s1_ff.d[W-1], s1_ff.d};
      mag_c = s1_ff.c[W-1] ? $unsigned(-ext_c) : $unsigned(ext_c);
      mag_d = s1_ff.d[W-1] ? $unsigned(-ext_d) : $unsigned(ext_d);
      s2_in        = s1_ff;
      s2_in.big_c  = (mag_c > mag_d);
      s2_in.dz     = (s1_ff.kind == cau_pkg::KIND_DIV) && (s1_ff.c == '0) && (s1_ff.d == '0);
      s2_in.res_re = '0;
      s2_in.res_im = '0;
      case (s1_ff.kind)
         cau_pkg::KIND_ADD: begin
            s2_in.res_re = cau_pkg::RES_W'(s1_ff.lr) + cau_pkg::RES_W'(s1_ff.c);
            s2_in.res_im = cau_pkg::RES_W'(s1_ff.li) + cau_pkg::RES_W'(s1_ff.d);
         end
         cau_pkg::KIND_SUB: begin
            s2_in.res_re = cau_pkg::RES_W'(s1_ff.lr) - cau_pkg::RES_W'(s1_ff.c);
            s2_in.res_im = cau_pkg::RES_W'(s1_ff.li) - cau_pkg::RES_W'(s1_ff.d);
         end
         cau_pkg::KIND_NEG: begin
            s2_in.res_re = -cau_pkg::RES_W'(s1_ff.lr);
            s2_in.res_im = -cau_pkg::RES_W'(s1_ff.li);
         end
         default: begin
            s2_in.res_re = '0;
            s2_in.res_im = '0;
         end
      endcase
      s2_p0_in = s1_ff.lr * s1_ff.c;
      s2_p1_in = s1_ff.li * s1_ff.d;
      s2_p2_in = s1_ff.li * s1_ff.c;
      s2_p3_in = s1_ff.lr * s1_ff.d;
      // Ratio: smaller divisor part over the larger
      if (s2_in.big_c) begin
         s2_num_in = cau_pkg::NUM_W'({mag_d, {F{1'b0}}});
         s2_den_in = cau_pkg::DEN_W'(mag_c);
      end else begin
         s2_num_in = cau_pkg::NUM_W'({mag_c, {F{1'b0}}});
         s2_den_in = cau_pkg::DEN_W'(mag_d);
      end
      s2_neg_in = s1_ff.c[W-1] ^ s1_ff.d[W-1];
   end

   // Finish the complex multiply ahead of the ratio divider
   always_comb begin
      diff_re   = PW'(s2_p0_ff) - (PW+1)'(s2_p1_ff);
      diff_im   = PW'(s2_p2_ff) + (PW+1)'(s2_p3_ff);
      d1_ctx_in = s2_ff;
      if (s2_ff.kind == cau_pkg::KIND_MUL) begin
         d1_ctx_in.res_re = cau_pkg::RES_W'(diff_re >>> F);
         d1_ctx_in.res_im = cau_pkg::RES_W'(diff_im >>> F);
      end
   end

   cau_div u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s2_vld_ff),
      .in_num_a  (s2_num_ff),
      .in_num_b  ('0),
      .in_den    (s2_den_ff),
      .in_neg_a  (s2_neg_ff),
      .in_neg_b  (1'b0),
      .in_ctx    (d1_ctx_in),
      .out_valid (d1_vld),
      .out_quo_a (d1_quo),
      .out_quo_b (),
      .out_neg_a (d1_neg),
      .out_neg_b (),
      .out_ctx   (d1_ctx)
   );

   // Sign the ratio
   assign m1_s_in = d1_neg ? $signed(-d1_quo[cau_pkg::S_W-1:0])
                           : $signed(d1_quo[cau_pkg::S_W-1:0]);

   // Scale the smaller divisor part and both left parts by the ratio
   always_comb begin
      m1_small  = m1_ff.big_c ? m1_ff.d : m1_ff.c;
      m2_psm_in = m1_s_ff * m1_small;
      m2_pl_in  = m1_s_ff * m1_ff.lr;
      m2_pi_in  = m1_s_ff * m1_ff.li;
   end

   // Build the Smith denominator and numerators
   always_comb begin
      sum_sd  = cau_pkg::SUM_W'(m2_psm_ff >>> F);
      sum_pl  = cau_pkg::SUM_W'(m2_pl_ff >>> F);
      sum_pi  = cau_pkg::SUM_W'(m2_pi_ff >>> F);
      if (m2_ff.big_c) begin
         sum_den = cau_pkg::SUM_W'(m2_ff.c) + sum_sd;
         sum_re  = cau_pkg::SUM_W'(m2_ff.lr) + sum_pi;
         sum_im  = cau_pkg::SUM_W'(m2_ff.li) - sum_pl;
      end else begin
         sum_den = cau_pkg::SUM_W'(m2_ff.d) + sum_sd;
         sum_re  = sum_pl + cau_pkg::SUM_W'(m2_ff.li);
         sum_im  = sum_pi - cau_pkg::SUM_W'(m2_ff.lr);
      end
      mag_den = sum_den[cau_pkg::SUM_W-1] ? $unsigned(-sum_den) : $unsigned(sum_den);
      mag_re  = sum_re[cau_pkg::SUM_W-1]  ? $unsigned(-sum_re)  : $unsigned(sum_re);
      mag_im  = sum_im[cau_pkg::SUM_W-1]  ? $unsigned(-sum_im)  : $unsigned(sum_im);
      d2_num_a_in = {mag_re[cau_pkg::NUM_W-F-1:0], {F{1'b0}}};
      d2_num_b_in = {mag_im[cau_pkg::NUM_W-F-1:0], {F{1'b0}}};
      d2_den_in   = mag_den[cau_pkg::DEN_W-1:0];
      d2_neg_a_in = sum_re[cau_pkg::SUM_W-1] ^ sum_den[cau_pkg::SUM_W-1];
      d2_neg_b_in = sum_im[cau_pkg::SUM_W-1] ^ sum_den[cau_pkg::SUM_W-1];
   end

   cau_div u_div_result (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m2_vld_ff),
      .in_num_a  (d2_num_a_in),
      .in_num_b  (d2_num_b_in),
      .in_den    (d2_den_in),
      .in_neg_a  (d2_neg_a_in),
      .in_neg_b  (d2_neg_b_in),
      .in_ctx    (m2_ff),
      .out_valid (d2_vld),
      .out_quo_a (d2_quo_a),
      .out_quo_b (d2_quo_b),
      .out_neg_a (d2_neg_a),
      .out_neg_b (d2_neg_b),
      .out_ctx   (d2_ctx)
   );

   // Take the signed quotients for a divide with a nonzero divisor
   always_comb begin
      f1_in = d2_ctx;
      if ((d2_ctx.kind == cau_pkg::KIND_DIV) && !d2_ctx.dz) begin
         f1_in.res_re = d2_neg_a ? -cau_pkg::RES_W'(d2_quo_a) : cau_pkg::RES_W'(d2_quo_a);
         f1_in.res_im = d2_neg_b ? -cau_pkg::RES_W'(d2_quo_b) : cau_pkg::RES_W'(d2_quo_b);
      end
   end

   // Clip each part to the word range
   always_comb begin
      top_re = f1_ff.res_re[cau_pkg::RES_W-1:W-1];
      top_im = f1_ff.res_im[cau_pkg::RES_W-1:W-1];
      ovf_re = !((&top_re) || !(|top_re));
      ovf_im = !((&top_im) || !(|top_im));
      if (ovf_re) begin
         rsp_re_in = top_re[TW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         rsp_re_in = f1_ff.res_re[W-1:0];
      end
      if (ovf_im) begin
         rsp_im_in = top_im[TW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         rsp_im_in = f1_ff.res_im[W-1:0];
      end
      rsp_sat_in = ovf_re || ovf_im;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         m1_vld_ff    <= 1'b0;
         m2_vld_ff    <= 1'b0;
         f1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         m1_vld_ff    <= d1_vld;
         m2_vld_ff    <= m1_vld_ff;
         f1_vld_ff    <= d2_vld;
         rsp_valid_ff <= f1_vld_ff;
      end
   end

   // Advance payloads, hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s2_p0_ff   <= s2_p0_in;
         s2_p1_ff   <= s2_p1_in;
         s2_p2_ff   <= s2_p2_in;
         s2_p3_ff   <= s2_p3_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_neg_ff  <= s2_neg_in;
         m1_ff      <= d1_ctx;
         m1_s_ff    <= m1_s_in;
         m2_ff      <= m1_ff;
         m2_psm_ff  <= m2_psm_in;
         m2_pl_ff   <= m2_pl_in;
         m2_pi_ff   <= m2_pi_in;
         f1_ff      <= f1_in;
         rsp_re_ff  <= rsp_re_in;
         rsp_im_ff  <= rsp_im_in;
         rsp_dz_ff  <= f1_ff.dz;
         rsp_sat_ff <= rsp_sat_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_re      = rsp_re_ff;
   assign rsp_result_im      = rsp_im_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the complex arithmetic unit: directed and random operations.
`timescale 1ns / 1ps

module tb_top;
   import cau_pkg::*;

   typedef logic signed [127:0]          exact_t;
   typedef logic signed [WORD_BITS-1:0]  word_t;

   typedef struct {
      word_t re;
      word_t im;
      logic  dz;
      logic  sat;
   } cplx_result_t;

   localparam int STALL_PCT   = 27;
   localparam int DRAIN_WAIT  = 200;
   localparam int QUIET_LIMIT = 5000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = KIND_ADD;
   word_t               req_left_re = '0;
   word_t               req_left_im = '0;
   word_t               req_right_re = '0;
   word_t               req_right_im = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   word_t               rsp_result_re;
   word_t               rsp_result_im;
   logic                rsp_divide_by_zero;
   logic                rsp_saturated;

   cplx_result_t        pending_results[$];
   int                  fail_count = 0;
   int                  quiet_cycles = 0;
   bit                  idle_on = 1'b1;

   complex_arithmetic_unit u_dut (.*);

   always #5 clock = ~clock;

   // Exact fixed-point helpers at full width
   function automatic exact_t fx_mul(exact_t a, exact_t b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic exact_t fx_div(exact_t a, exact_t b);
      return (a <<< FRAC_BITS) / b;
   endfunction

   function automatic exact_t mag(exact_t a);
      return (a < 0) ? -a : a;
   endfunction

   // Clip to the word range, flag when clipped
   function automatic word_t clip_word(exact_t v, ref logic sat);
      exact_t top;
      exact_t bot;
      top = (exact_t'(1) <<< (WORD_BITS - 1)) - 1;
      bot = -(exact_t'(1) <<< (WORD_BITS - 1));
      if (v > top) begin
         sat = 1'b1;
         return word_t'(top);
      end
      if (v < bot) begin
         sat = 1'b1;
         return word_t'(bot);
      end
      return word_t'(v);
   endfunction

   function automatic cplx_result_t complex_result(logic [KIND_W-1:0] kind, word_t a_re,
                                                   word_t a_im, word_t b_re, word_t b_im);
      exact_t       lr;
      exact_t       li;
      exact_t       c;
      exact_t       d;
      exact_t       re;
      exact_t       im;
      exact_t       s;
      exact_t       den;
      logic         sat;
      cplx_result_t r;
      lr = a_re;
      li = a_im;
      c = b_re;
      d = b_im;
      re = 0;
      im = 0;
      sat = 1'b0;
      r.dz = 1'b0;
      case (kind)
         KIND_ADD: begin
            re = lr + c;
            im = li + d;
         end
         KIND_SUB: begin
            re = lr - c;
            im = li - d;
         end
         KIND_MUL: begin
            re = (lr * c - li * d) >>> FRAC_BITS;
            im = (li * c + lr * d) >>> FRAC_BITS;
         end
         KIND_DIV: begin
            if (c == 0 && d == 0) begin
               r.dz = 1'b1;
            end else if (mag(c) > mag(d)) begin
               s = fx_div(d, c);
               den = c + fx_mul(s, d);
               re = fx_div(lr + fx_mul(s, li), den);
               im = fx_div(li - fx_mul(s, lr), den);
            end else begin
               s = fx_div(c, d);
               den = d + fx_mul(s, c);
               re = fx_div(fx_mul(lr, s) + li, den);
               im = fx_div(fx_mul(li, s) - lr, den);
            end
         end
         KIND_NEG: begin
            re = -lr;
            im = -li;
         end
         default: ;
      endcase
      r.re = clip_word(re, sat);
      r.im = clip_word(im, sat);
      r.sat = sat;
      return r;
   endfunction

   // Send one word and record its expected result once accepted
   task automatic send_word(logic [KIND_W-1:0] kind, word_t a_re, word_t a_im,
                            word_t b_re, word_t b_im);
      while (idle_on && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_left_re <= a_re;
      req_left_im <= a_im;
      req_right_re <= b_re;
      req_right_im <= b_im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(complex_result(kind, a_re, a_im, b_re, b_im));
   endtask

   task automatic end_words();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Mix full-range, small and extreme operands
   function automatic word_t pick_operand();
      case ($urandom_range(9))
         0, 1, 2: return word_t'($urandom);
         3:       return word_t'($urandom_range(1, 1 << 20));
         4:       return -word_t'($urandom_range(1, 1 << 20));
         5:       return word_t'(1 << WORD_BITS - 1);
         6:       return ~word_t'(1 << WORD_BITS - 1);
         7:       return '0;
         default: return word_t'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   task automatic test_directed();
      word_t wmax;
      word_t wmin;
      wmax = ~word_t'(1 << WORD_BITS - 1);
      wmin = word_t'(1 << WORD_BITS - 1);
      send_word(KIND_ADD, wmax, wmin, wmax, wmin);
      send_word(KIND_ADD, 32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000, 32'sh0000_4000);
      send_word(KIND_SUB, wmin, wmax, wmax, wmin);
      send_word(KIND_SUB, 32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000);
      send_word(KIND_MUL, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000, 32'sh0000_8000);
      send_word(KIND_MUL, wmax, wmin, wmax, wmin);
      send_word(KIND_MUL, wmin, wmin, wmin, wmin);
      send_word(KIND_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0);
      send_word(KIND_DIV, wmax, wmin, 0, 0);
      send_word(KIND_DIV, 32'sh0004_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0001_0000);
      send_word(KIND_DIV, 32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000, -32'sh0003_0000);
      send_word(KIND_DIV, 32'sh0004_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000);
      send_word(KIND_DIV, wmax, wmax, 1, 0);
      send_word(KIND_DIV, wmin, wmin, 0, -1);
      send_word(KIND_DIV, wmin, wmax, wmin, wmin);
      send_word(KIND_DIV, wmax, wmin, wmin, wmax);
      send_word(KIND_NEG, wmin, wmin, wmax, wmax);
      send_word(KIND_NEG, wmax, 32'sh0001_0000, 0, 0);
      send_word(KIND_NEG, 0, wmin, wmin, 0);
      send_word(3'd5, wmax, wmax, wmax, wmax);
      send_word(3'd6, wmin, 32'sh0001_0000, 0, 0);
      send_word(3'd7, 1, -1, 1, -1);
      end_words();
   endtask

   task automatic test_random(int count);
      logic [KIND_W-1:0] kind;
      for (int i = 0; i < count; i++) begin
         kind = ($urandom_range(19) == 0) ? KIND_W'($urandom_range(5, 7))
                                          : KIND_W'($urandom_range(0, 4));
         send_word(kind, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
      end_words();
   endtask

   // Hold off the sender until the pipeline has drained
   task automatic test_drain_pause();
      test_random(30);
      wait_drained();
      test_random(20);
   endtask

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= idle_on ? ($urandom_range(99) < STALL_PCT) : 1'b0;
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      cplx_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result word with no expectation pending");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_re !== want.re) begin
               $error("result_re: expected %0d, got %0d", want.re, rsp_result_re);
               fail_count++;
            end
            if (rsp_result_im !== want.im) begin
               $error("result_im: expected %0d, got %0d", want.im, rsp_result_im);
               fail_count++;
            end
            if (rsp_divide_by_zero !== want.dz) begin
               $error("divide_by_zero: expected %0b, got %0b", want.dz, rsp_divide_by_zero);
               fail_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated: expected %0b, got %0b", want.sat, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random(350);
      idle_on = 1'b0;
      test_random(150);
      idle_on = 1'b1;
      test_random(300);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
hdl/cau_pkg.sv
hdl/cau_div.sv
hdl/complex_arithmetic_unit.sv
dv/tb_top.sv
